### rtl/fyds_pkg.sv
// Shared types and constants for the Fisher-Yates deck shuffle unit.
`default_nettype none

package fyds_pkg;

    localparam int DECK_SIZE = 52;
    localparam int IDX_W     = $clog2(DECK_SIZE);
    localparam int CARD_W    = 6;
    localparam int RAND_W    = 31;
    localparam int DIV_CNT_W = $clog2(RAND_W);

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx LAST_POS = t_idx'(DECK_SIZE - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD_P,
        S_RD_J,
        S_WR_P,
        S_WR_J,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    typedef struct packed {
        logic load_word;
        logic div_step;
        logic rd_pos;
        logic rd_j;
        logic wr_pos;
        logic wr_j;
        logic pos_dec;
        logic emit_rd;
        logic emit_ld;
        logic restore;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic pos_last;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### rtl/fisher_yates_deck_shuffle_unit.sv
// Fisher-Yates deck shuffle unit: top level joining the controller and the datapath.
//
// Input channel (i_in_valid / o_in_stall / i_rand_word): each item is one
// random word. The word is reduced modulo (position + 1) by a bit-serial
// remainder unit, one bit per cycle, and the entries at the position and at
// the remainder are swapped in the permutation RAM. Position counts down from
// DECK_SIZE-1 to 1.
// An item occupies the block for 31 remainder steps, four RAM accesses for the
// swap (two reads and two writes on the RAM's read port and write port) and
// the return to idle, or the emit run after the final item. o_in_stall is high during that time.
// Output channel (o_out_valid / i_out_stall): after the item that swaps at
// position one, the block emits DECK_SIZE items, slot 0 first, o_last_slot on
// the final one. Each slot is a RAM read followed by an output register load;
// a stall holds the output register and the
// emit run waits. The block then restores the identity order and accepts the
// first item of the next shuffle while the last slot may still wait.
// Reset restores the identity order at once through per-entry valid bits, so
// no clearing pass is needed, and clears the output valid.
`default_nettype none

module fisher_yates_deck_shuffle_unit
    import fyds_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [RAND_W-1:0] i_rand_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [CARD_W-1:0] o_card_value,
    output logic      [CARD_W-1:0] o_slot_index,
    output logic                   o_last_slot
);

    t_cmd    w_cmd;
    t_status w_status;

    fyds_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_status  (w_status),
        .o_in_stall(o_in_stall),
        .o_cmd     (w_cmd)
    );

    fyds_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rand_word (i_rand_word),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_card_value(o_card_value),
        .o_slot_index(o_slot_index),
        .o_last_slot (o_last_slot)
    );

endmodule

`default_nettype wire

### rtl/fyds_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fyds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/fyds_ctrl.sv
// Controller state machine: sequences the modulo, the swap and the emit run.
`default_nettype none

module fyds_ctrl
    import fyds_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_stall,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_word = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_RD_P;
                end
            end
            S_RD_P: begin
                o_cmd.rd_pos = 1'b1;
                n_state      = S_RD_J;
            end
            S_RD_J: begin
                o_cmd.rd_j = 1'b1;
                n_state    = S_WR_P;
            end
            S_WR_P: begin
                o_cmd.wr_pos = 1'b1;
                n_state      = S_WR_J;
            end
            S_WR_J: begin
                o_cmd.wr_j = 1'b1;
                if (i_status.pos_last) begin
                    n_state = S_EMIT_RD;
                end else begin
                    o_cmd.pos_dec = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                // Hold the read data until the output register can take it.
                if (i_status.out_free) begin
                    o_cmd.emit_ld = 1'b1;
                    if (i_status.emit_last) begin
                        o_cmd.restore = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/fyds_datapath.sv
// Datapath: bit-serial modulo, permutation store with valid bits, output register.
`default_nettype none

module fyds_datapath
    import fyds_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [RAND_W-1:0] i_rand_word,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic      [CARD_W-1:0] o_card_value,
    output logic      [CARD_W-1:0] o_slot_index,
    output logic                   o_last_slot
);

    // Modulo unit: one quotient bit per cycle, remainder kept below pos + 1.
    logic [RAND_W-1:0]    r_word;
    t_idx                 r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [IDX_W:0]       w_div;
    logic [IDX_W:0]       w_trial;
    logic [IDX_W:0]       w_sub;

    t_idx               r_pos;
    t_idx               r_slot;
    logic [DECK_SIZE-1:0] r_vld;
    t_idx               r_held;
    t_idx               r_rd_addr;
    logic               r_rd_vld;

    logic       r_out_valid;
    t_idx       r_out_card;
    t_idx       r_out_slot;
    logic       r_out_last;

    logic       w_re;
    t_idx       w_raddr;
    logic       w_we;
    t_idx       w_waddr;
    t_idx       w_wdata;
    t_idx       w_rdata;
    t_idx       w_eff;

    assign w_div   = {1'b0, r_pos} + (IDX_W + 1)'(1);
    assign w_trial = {r_rem, r_word[RAND_W-1]};
    assign w_sub   = w_trial - w_div;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_word <= i_rand_word;
            r_rem  <= '0;
            r_cnt  <= DIV_CNT_W'(RAND_W - 1);
        end else if (i_cmd.div_step) begin
            r_word <= {r_word[RAND_W-2:0], 1'b0};
            r_rem  <= (w_trial >= w_div) ? w_sub[IDX_W-1:0] : w_trial[IDX_W-1:0];
            r_cnt  <= r_cnt - DIV_CNT_W'(1);
        end
    end

    // Read port: swap reads and emit reads share it.
    always_comb begin
        w_re    = i_cmd.rd_pos | i_cmd.rd_j | i_cmd.emit_rd;
        w_raddr = r_slot;
        if (i_cmd.rd_pos) begin
            w_raddr = r_pos;
        end else if (i_cmd.rd_j) begin
            w_raddr = r_rem;
        end
    end

    // An entry never written since the last restore still holds its own index.
    assign w_eff = r_rd_vld ? w_rdata : r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_addr <= w_raddr;
            r_rd_vld  <= r_vld[w_raddr];
        end
        if (i_cmd.rd_j) begin
            r_held <= w_eff;
        end
    end

    assign w_we    = i_cmd.wr_pos | i_cmd.wr_j;
    assign w_waddr = i_cmd.wr_pos ? r_pos : r_rem;
    assign w_wdata = i_cmd.wr_pos ? w_eff : r_held;

    fyds_ram #(
        .WIDTH(IDX_W),
        .DEPTH(DECK_SIZE)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_pos  <= LAST_POS;
            r_slot <= '0;
        end else if (i_cmd.restore) begin
            r_vld  <= '0;
            r_pos  <= LAST_POS;
            r_slot <= '0;
        end else begin
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
            if (i_cmd.pos_dec) begin
                r_pos <= r_pos - t_idx'(1);
            end
            if (i_cmd.emit_ld) begin
                r_slot <= r_slot + t_idx'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ld) begin
            r_out_card <= w_eff;
            r_out_slot <= r_slot;
            r_out_last <= (r_slot == LAST_POS);
        end
    end

    assign o_status.div_last  = (r_cnt == '0);
    assign o_status.pos_last  = (r_pos == t_idx'(1));
    assign o_status.emit_last = (r_slot == LAST_POS);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_card_value = CARD_W'(r_out_card);
    assign o_slot_index = CARD_W'(r_out_slot);
    assign o_last_slot  = r_out_last;

endmodule

`default_nettype wire

### rtl/fyds_checker.sv
// Port-level checker for the shuffle unit, attached by bind.
`default_nettype none

module fyds_checker
    import fyds_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [CARD_W-1:0] o_card_value,
    input wire logic [CARD_W-1:0] o_slot_index,
    input wire logic              o_last_slot
);

    // The input is always stalled in the cycle after an accepted item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted item");

    // The last marker sits exactly on the final slot.
    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_slot == (o_slot_index == CARD_W'(DECK_SIZE - 1))))
        else $error("last marker and slot index disagree");

    // Every emitted card is a card of the deck.
    a_card_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_card_value < CARD_W'(DECK_SIZE)))
        else $error("card value outside the deck");

    // A slot that follows an accepted non-final slot is the next one.
    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_slot) ##1 o_out_valid
            |-> (o_slot_index == $past(o_slot_index) + CARD_W'(1)))
        else $error("slot index did not advance by one");

    // A stalled item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_card_value) && $stable(o_slot_index)))
        else $error("stalled output item changed");

endmodule

bind fisher_yates_deck_shuffle_unit fyds_checker u_fyds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_card_value(o_card_value),
    .o_slot_index(o_slot_index),
    .o_last_slot (o_last_slot)
);

`default_nettype wire

### verif/fisher_yates_deck_shuffle_unit_tb.sv
// Self-checking testbench for the Fisher-Yates deck shuffle unit.
`timescale 1ns / 1ps

module fisher_yates_deck_shuffle_unit_tb;
    import fyds_pkg::*;

    localparam int TOTAL_WORDS = 310;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        logic [CARD_W-1:0] card;
        logic [CARD_W-1:0] slot;
        logic              last;
    } t_slot_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [RAND_W-1:0] i_rand_word;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [CARD_W-1:0] o_card_value;
    logic [CARD_W-1:0] o_slot_index;
    logic              o_last_slot;

    // Shadow copy of the permutation and the countdown position.
    logic [CARD_W-1:0] deck_order [DECK_SIZE];
    t_idx              swap_pos;
    t_slot_result      pending_slots [$];

    int error_count;
    int words_sent;
    int slots_checked;
    int shuffles_done;
    int out_stall_mode;
    bit in_gaps_on;

    fisher_yates_deck_shuffle_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rand_word  (i_rand_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_card_value (o_card_value),
        .o_slot_index (o_slot_index),
        .o_last_slot  (o_last_slot)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void restore_deck();
        for (int k = 0; k < DECK_SIZE; k++) begin
            deck_order[k] = CARD_W'(k);
        end
        swap_pos = LAST_POS;
    endfunction

    // One swap step; the step at position one releases the whole permutation.
    function automatic void apply_swap_step(input logic [RAND_W-1:0] word);
        t_idx              pos;
        t_idx              partner;
        logic [CARD_W-1:0] held;
        t_slot_result      res;
        pos = (swap_pos < 1 || swap_pos > LAST_POS) ? LAST_POS : swap_pos;
        partner = t_idx'(32'(word) % (32'(pos) + 32'd1));
        held = deck_order[pos];
        deck_order[pos] = deck_order[partner];
        deck_order[partner] = held;
        if (pos > 1) begin
            swap_pos = pos - 1'b1;
        end else begin
            for (int k = 0; k < DECK_SIZE; k++) begin
                res.card = deck_order[k];
                res.slot = CARD_W'(k);
                res.last = (k == DECK_SIZE - 1);
                pending_slots.push_back(res);
            end
            restore_deck();
            shuffles_done++;
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(0, 2);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [RAND_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            return RAND_W'($urandom);
        end
        if (sel < 68) begin
            return '1;
        end
        if (sel < 75) begin
            return '0;
        end
        if (sel < 85) begin
            return RAND_W'(swap_pos);
        end
        if (sel < 92) begin
            return RAND_W'(32'($urandom_range(1, 1000)) * (32'(swap_pos) + 32'd1));
        end
        return RAND_W'($urandom_range(0, 63));
    endfunction

    task automatic send_word(input logic [RAND_W-1:0] word);
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_rand_word = word;
        do @(posedge i_clk); while (o_in_stall);
        apply_swap_step(word);
        words_sent++;
    endtask

    task automatic idle_input(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid  = 1'b0;
            i_rand_word = RAND_W'($urandom);
        end
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_word(pick_word());
            if (in_gaps_on) begin
                idle_input(gap_len());
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_slots.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Field extremes, single set bits, alternating patterns, and words that pick
    // the position itself or slot zero as partner.
    task automatic test_word_extremes();
        logic [RAND_W-1:0] fixed_words [8];
        fixed_words = '{31'h0000_0000, 31'h7FFF_FFFF, 31'h0000_0001, 31'h4000_0000,
                        31'h5555_5555, 31'h2AAA_AAAA, 31'h7FFF_FFFE, 31'h0000_FFFF};
        in_gaps_on     = 1'b1;
        out_stall_mode = 1;
        foreach (fixed_words[k]) begin
            send_word(fixed_words[k]);
            idle_input(gap_len());
        end
        send_word(RAND_W'(swap_pos));
        send_word(RAND_W'(32'(swap_pos) + 32'd1));
        send_word(RAND_W'(2 * 32'(swap_pos) + 32'd1));
        send_word(RAND_W'((32'h7FFF_FFFF / (32'(swap_pos) + 1)) * (32'(swap_pos) + 1)));
    endtask

    // Finish the current shuffle back to back, then hold the sender until every
    // slot of the permutation has come out.
    task automatic test_shuffle_then_drain();
        int start_count;
        start_count    = shuffles_done;
        in_gaps_on     = 1'b0;
        out_stall_mode = 0;
        while (shuffles_done == start_count) begin
            send_word(pick_word());
        end
        idle_input(1);
        wait_drained();
    endtask

    // Random words in chunks, each chunk with its own idling on both sides, so a
    // new shuffle often starts while the previous permutation is still stalled.
    task automatic test_random_shuffles();
        int chunk;
        while (words_sent < TOTAL_WORDS) begin
            chunk = $urandom_range(5, 30);
            if (chunk > TOTAL_WORDS - words_sent) begin
                chunk = TOTAL_WORDS - words_sent;
            end
            in_gaps_on     = ($urandom_range(0, 3) != 0);
            out_stall_mode = $urandom_range(0, 2);
            send_random(chunk);
        end
        idle_input(1);
    endtask

    initial begin : out_stall_driver
        int hold;
        hold        = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (out_stall_mode == 0) begin
                i_out_stall = 1'b0;
                hold        = $urandom_range(1, 8);
            end else begin
                i_out_stall = ($urandom_range(0, 99) < (out_stall_mode == 2 ? 60 : 25));
                hold        = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_slot_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_slots.size() == 0) begin
                $error("unexpected item: slot_index %0d card_value %0d",
                       o_slot_index, o_card_value);
                error_count++;
            end else begin
                want = pending_slots.pop_front();
                slots_checked++;
                if (o_card_value !== want.card) begin
                    $error("card_value mismatch: expected %0d, actual %0d",
                           want.card, o_card_value);
                    error_count++;
                end
                if (o_slot_index !== want.slot) begin
                    $error("slot_index mismatch: expected %0d, actual %0d",
                           want.slot, o_slot_index);
                    error_count++;
                end
                if (o_last_slot !== want.last) begin
                    $error("last_slot mismatch: expected %0d, actual %0d",
                           want.last, o_last_slot);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("fisher_yates_deck_shuffle_unit_tb: FAIL");
        $finish;
    end

    initial begin
        error_count    = 0;
        words_sent     = 0;
        slots_checked  = 0;
        shuffles_done  = 0;
        out_stall_mode = 0;
        in_gaps_on     = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_rand_word    = '0;
        restore_deck();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_word_extremes();
        test_shuffle_then_drain();
        test_random_shuffles();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d random words, finishing %0d shuffles; %0d output slots checked.",
                 words_sent, shuffles_done, slots_checked);
        if (error_count == 0) begin
            $display("fisher_yates_deck_shuffle_unit_tb: PASS");
        end else begin
            $display("fisher_yates_deck_shuffle_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
